// ===== rtl/lbps_pkg.sv =====
// Shared types, codes and helper functions for the LED bar pattern shifter.
// No dependencies; all other files but lbps_rsp_if and lbps_checker use it.
package lbps_pkg;

   localparam int FUNC_W      = 3;
   localparam int MODE_W      = 3;
   localparam int AMOUNT_W    = 24;
   localparam int PATTERN_W   = 16;
   localparam int INDEX_W     = 8;
   localparam int FSCALE_W    = 23;
   localparam int BIT_IDX_W   = 4;
   localparam int BAR_MODE_W  = 2;
   localparam int QUO_W       = 17;
   localparam int PRODUCT_W   = FSCALE_W + QUO_W;
   localparam int STEP_W      = 5;

   localparam logic [FSCALE_W-1:0] FULL_SCALE_RESET = 23'd25600;

   // command codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_DOT     = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_BAR     = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SETBIT  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_REFRESH = 3'd5;

   // dot widths
   localparam logic [MODE_W-1:0] DOT_W1 = 3'd1;
   localparam logic [MODE_W-1:0] DOT_W2 = 3'd2;
   localparam logic [MODE_W-1:0] DOT_W4 = 3'd3;
   localparam logic [MODE_W-1:0] DOT_W8 = 3'd4;

   // bar styles
   localparam logic [BAR_MODE_W-1:0] BAR_PMBIT8 = 2'd0;
   localparam logic [BAR_MODE_W-1:0] BAR_PMLIN8 = 2'd1;
   localparam logic [BAR_MODE_W-1:0] BAR_PBIT16 = 2'd2;
   localparam logic [BAR_MODE_W-1:0] BAR_PLIN16 = 2'd3;

   localparam logic [PATTERN_W-1:0] PM_POS_FULL = 16'h00FF;
   localparam logic [PATTERN_W-1:0] PM_NEG_FULL = 16'hFF00;
   localparam logic [PATTERN_W-1:0] ALL_ON      = 16'hFFFF;

   // LED order on the serial line, first bit first
   localparam logic [BIT_IDX_W-1:0] SHIFT_SEQ [PATTERN_W] = '{
      4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0, 4'd7,
      4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8, 4'd15
   };

   typedef enum logic [1:0] {
      CMD_STORE,
      CMD_SETBIT,
      CMD_BAR,
      CMD_REFRESH
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                 kind;
      logic [PATTERN_W-1:0]         pattern;
      logic [BIT_IDX_W-1:0]         bit_idx;
      logic                         bit_on;
      logic [BAR_MODE_W-1:0]        bar_mode;
      logic signed [AMOUNT_W-1:0]   level;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic [7:0] rev8(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = b[i];
      end
      return r;
   endfunction

   // lowest n bits set, saturating at all sixteen
   function automatic logic [PATTERN_W-1:0] ones16(input logic [4:0] n);
      logic [PATTERN_W-1:0] r;
      if (n >= 5'd16) begin
         r = ALL_ON;
      end else begin
         r = (16'h0001 << n[3:0]) - 16'h0001;
      end
      return r;
   endfunction

   function automatic logic [PATTERN_W-1:0] permute_pattern(
      input logic [PATTERN_W-1:0] p
   );
      logic [PATTERN_W-1:0] r;
      for (int k = 0; k < PATTERN_W; k++) begin
         r[k] = p[SHIFT_SEQ[k]];
      end
      return r;
   endfunction

endpackage

// ===== rtl/lbps_req_if.sv =====
// Command channel of the LED bar pattern shifter: valid/ready plus payload.
// Depends on lbps_pkg for field widths.
interface lbps_req_if;
   logic                                valid;
   logic                                ready;
   logic [lbps_pkg::FUNC_W-1:0]         func;
   logic [lbps_pkg::MODE_W-1:0]         mode;
   logic signed [lbps_pkg::AMOUNT_W-1:0] amount;
   logic [lbps_pkg::PATTERN_W-1:0]      new_pattern;
   logic [lbps_pkg::INDEX_W-1:0]        bit_index;
   logic                                bit_on;

   modport source (output valid, func, mode, amount, new_pattern, bit_index, bit_on,
                   input ready);
   modport sink   (input valid, func, mode, amount, new_pattern, bit_index, bit_on,
                   output ready);
endinterface

// ===== rtl/lbps_rsp_if.sv =====
// Serial bit channel of the LED bar pattern shifter: valid/ready plus payload.
// No dependencies.
interface lbps_rsp_if;
   logic valid;
   logic ready;
   logic serial_bit;
   logic latch_after;

   modport source (output valid, serial_bit, latch_after, input ready);
   modport sink   (input valid, serial_bit, latch_after, output ready);
endinterface

// ===== rtl/lbps_front.sv =====
// Front end: accepts commands, drops the invalid ones, and turns the
// rest into queue entries. Depends on lbps_pkg and lbps_req_if.
module lbps_front (
   lbps_req_if.sink                req,
   input  lbps_pkg::queue_status_type q_status,
   output logic                    push_valid,
   output lbps_pkg::cmd_type       push_data
);
   import lbps_pkg::*;

   logic [PATTERN_W-1:0] pos;
   logic [PATTERN_W-1:0] dot_pattern;
   logic                 accept;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && !q_status.full;
   assign pos       = req.amount[PATTERN_W-1:0];

   // a dot wholly past bit 15 darkens everything
   always_comb begin
      unique case (req.mode)
         DOT_W1:  dot_pattern = (pos < 16'd16) ? (16'h0001 << pos[3:0]) : '0;
         DOT_W2:  dot_pattern = (pos < 16'd8) ? (16'h0003 << {pos[2:0], 1'b0}) : '0;
         DOT_W4:  dot_pattern = (pos < 16'd4) ? (16'h000F << {pos[1:0], 2'b00}) : '0;
         DOT_W8:  dot_pattern = (pos < 16'd2) ? (16'h00FF << {pos[0], 3'b000}) : '0;
         default: dot_pattern = pos;
      endcase
   end

   always_comb begin
      push_data.kind     = CMD_STORE;
      push_data.pattern  = req.new_pattern;
      push_data.bit_idx  = req.bit_index[BIT_IDX_W-1:0];
      push_data.bit_on   = req.bit_on;
      push_data.bar_mode = req.mode[BAR_MODE_W-1:0];
      push_data.level    = req.amount;
      push_valid         = 1'b0;
      unique case (req.func)
         FUNC_LOAD: begin
            push_valid = accept;
         end
         FUNC_DOT: begin
            push_data.pattern = dot_pattern;
            push_valid        = accept;
         end
         FUNC_BAR: begin
            push_data.kind = CMD_BAR;
            push_valid     = accept && (req.mode[MODE_W-1:BAR_MODE_W] == '0);
         end
         FUNC_SETBIT: begin
            push_data.kind = CMD_SETBIT;
            push_valid     = accept && (req.bit_index[INDEX_W-1:BIT_IDX_W] == '0);
         end
         FUNC_CLEAR: begin
            push_data.pattern = '0;
            push_valid        = accept;
         end
         FUNC_REFRESH: begin
            push_data.kind = CMD_REFRESH;
            push_valid     = accept;
         end
         default: begin
            push_valid = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/lbps_cmd_queue.sv =====
// Short command queue between front and back end, held in flip-flops.
// Depends on lbps_pkg for the entry type.
module lbps_cmd_queue #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  lbps_pkg::cmd_type          push_data,
   input  logic                       pop,
   output lbps_pkg::cmd_type          head,
   output lbps_pkg::queue_status_type status
);
   import lbps_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   cmd_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic              do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL_CNT);
   assign head         = entry_ff[rd_ptr_ff];
   assign do_push      = push_valid && !status.full;
   assign do_pop       = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/lbps_back.sv =====
// Back end: owns the LED pattern and dirty flag, runs the bar divider and
// the serial sender. Depends on lbps_pkg and lbps_rsp_if.
module lbps_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lbps_pkg::FSCALE_W-1:0] full_scale,
   input  lbps_pkg::queue_status_type    q_status,
   input  lbps_pkg::cmd_type             cmd,
   output logic                          cmd_pop,
   lbps_rsp_if.source                    rsp
);
   import lbps_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_PREP = 5'b00010,
      S_DIV  = 5'b00100,
      S_DONE = 5'b01000,
      S_SEND = 5'b10000
   } state_type;

   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(QUO_W - 1);
   localparam logic [3:0]        SEND_LAST = 4'(PATTERN_W - 1);

   state_type              state_ff, state_in;
   logic [PATTERN_W-1:0]   pattern_ff, pattern_in;
   logic                   dirty_ff, dirty_in;
   logic [FSCALE_W-1:0]    mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [BAR_MODE_W-1:0]  bmode_ff, bmode_in;
   logic [FSCALE_W-1:0]    rem_ff, rem_in;
   logic [QUO_W-1:0]       quo_ff, quo_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [PATTERN_W-1:0]   perm_ff, perm_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_bit_ff, rsp_bit_in;
   logic                   rsp_latch_ff, rsp_latch_in;

   logic [FSCALE_W-1:0]        fs_eff;
   logic signed [FSCALE_W+1:0] fs_s, lvl_s, lvl_abs;
   logic [PRODUCT_W-1:0]       mag_wide, product;
   logic [FSCALE_W:0]          trial, trial_sub;
   logic                       trial_ge;
   logic [PATTERN_W-1:0]       lin_mask;

   assign fs_eff  = (full_scale == '0) ? FSCALE_W'(1) : full_scale;
   assign fs_s    = signed'({2'b00, fs_eff});
   assign lvl_s   = (FSCALE_W+2)'(cmd.level);
   assign lvl_abs = (lvl_s < 0) ? -lvl_s : lvl_s;

   assign mag_wide = PRODUCT_W'(mag_ff);
   always_comb begin
      unique case (bmode_ff)
         BAR_PMBIT8: product = (mag_wide << 8) - mag_wide;
         BAR_PMLIN8: product = mag_wide << 3;
         BAR_PBIT16: product = (mag_wide << 16) - mag_wide;
         default:    product = mag_wide << 4;
      endcase
   end

   // one restoring step: remainder stays below full_scale
   assign trial     = {rem_ff, quo_ff[QUO_W-1]};
   assign trial_ge  = (trial >= {1'b0, fs_eff});
   assign trial_sub = trial - {1'b0, fs_eff};
   assign lin_mask  = ones16(quo_ff[4:0]);

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.serial_bit  = rsp_bit_ff;
   assign rsp.latch_after = rsp_latch_ff;

   always_comb begin
      state_in     = state_ff;
      pattern_in   = pattern_ff;
      dirty_in     = dirty_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      bmode_in     = bmode_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      perm_in      = perm_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_bit_in   = rsp_bit_ff;
      rsp_latch_in = rsp_latch_ff;
      cmd_pop      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (!q_status.empty) begin
               cmd_pop = 1'b1;
               unique case (cmd.kind)
                  CMD_STORE: begin
                     pattern_in = cmd.pattern;
                     dirty_in   = 1'b1;
                  end
                  CMD_SETBIT: begin
                     pattern_in[cmd.bit_idx] = cmd.bit_on;
                     dirty_in                = 1'b1;
                  end
                  CMD_BAR: begin
                     mag_in   = lvl_abs[FSCALE_W-1:0];
                     neg_in   = (lvl_s < 0);
                     bmode_in = cmd.bar_mode;
                     if (cmd.bar_mode == BAR_PMBIT8 || cmd.bar_mode == BAR_PMLIN8) begin
                        if (lvl_s >= fs_s) begin
                           pattern_in = PM_POS_FULL;
                           dirty_in   = 1'b1;
                        end else if (lvl_s <= -fs_s) begin
                           pattern_in = PM_NEG_FULL;
                           dirty_in   = 1'b1;
                        end else begin
                           state_in = S_PREP;
                        end
                     end else begin
                        if (lvl_s <= 0) begin
                           pattern_in = '0;
                           dirty_in   = 1'b1;
                        end else if (lvl_s > fs_s) begin
                           pattern_in = ALL_ON;
                           dirty_in   = 1'b1;
                        end else begin
                           state_in = S_PREP;
                        end
                     end
                  end
                  CMD_REFRESH: begin
                     if (dirty_ff) begin
                        perm_in  = permute_pattern(pattern_ff);
                        dirty_in = 1'b0;
                        step_in  = '0;
                        state_in = S_SEND;
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         S_PREP: begin
            rem_in   = product[PRODUCT_W-1:QUO_W];
            quo_in   = product[QUO_W-1:0];
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in  = trial_ge ? trial_sub[FSCALE_W-1:0] : trial[FSCALE_W-1:0];
            quo_in  = {quo_ff[QUO_W-2:0], trial_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            dirty_in = 1'b1;
            state_in = S_IDLE;
            unique case (bmode_ff)
               BAR_PMBIT8: pattern_in = neg_ff ? {quo_ff[7:0], 8'h00}
                                               : {8'h00, rev8(quo_ff[7:0])};
               BAR_PMLIN8: pattern_in = neg_ff ? {lin_mask[7:0], 8'h00}
                                               : {8'h00, rev8(lin_mask[7:0])};
               BAR_PBIT16: pattern_in = quo_ff[PATTERN_W-1:0];
               default:    pattern_in = lin_mask;
            endcase
         end
         S_SEND: begin
            // advance only when the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = perm_ff[0];
               rsp_latch_in = (step_ff[3:0] == SEND_LAST);
               perm_in      = perm_ff >> 1;
               step_in      = step_ff + 1'b1;
               if (step_ff[3:0] == SEND_LAST) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pattern_ff   <= '0;
         dirty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pattern_ff   <= pattern_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      bmode_ff     <= bmode_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      step_ff      <= step_in;
      perm_ff      <= perm_in;
      rsp_bit_ff   <= rsp_bit_in;
      rsp_latch_ff <= rsp_latch_in;
   end

endmodule

// ===== rtl/led_bar_pattern_shifter_core.sv =====
// Top level of the LED bar pattern shifter: full_scale register, front end,
// command queue and back end. Depends on lbps_pkg, the channel interfaces,
// lbps_front, lbps_cmd_queue and lbps_back.
//
//   channel   direction  handshake            payload
//   req_if    in         valid/ready          func, mode, amount, new_pattern,
//                                             bit_index, bit_on
//   rsp_if    out        valid/ready          serial_bit, latch_after
//   csr       in         csr_wr_en            csr_wr_data (full_scale)
//
// Load, dot, set-bit and clear update the pattern one cycle after acceptance
// when the back end is idle. An in-range level bar runs in the back end through
// one compare, one product, 17 restoring divider steps against full_scale and one
// step to form the bar. A dirty refresh holds the back end while it loads the
// permuted pattern and sends its 16 serial bits, stretched by every cycle rsp_if.ready is low.
// The queue keeps taking commands while the back end works; req_if.ready
// falls only when it is full. Synchronous reset clears the pattern, the dirty
// flag, the queue and the output, and sets full_scale to 100.0.
module led_bar_pattern_shifter_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   lbps_req_if.sink                      req_if,
   lbps_rsp_if.source                    rsp_if,
   input  logic                          csr_wr_en,
   input  logic [lbps_pkg::FSCALE_W-1:0] csr_wr_data
);
   import lbps_pkg::*;

   logic [FSCALE_W-1:0] full_scale_ff;
   queue_status_type    q_status;
   logic                push_valid;
   cmd_type             push_data;
   cmd_type             head;
   logic                cmd_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= FULL_SCALE_RESET;
      end else if (csr_wr_en) begin
         full_scale_ff <= csr_wr_data;
      end
   end

   lbps_front u_front (
      .req        (req_if),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   lbps_cmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (cmd_pop),
      .head       (head),
      .status     (q_status)
   );

   lbps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .full_scale (full_scale_ff),
      .q_status   (q_status),
      .cmd        (head),
      .cmd_pop    (cmd_pop),
      .rsp        (rsp_if)
   );

endmodule

// ===== rtl/lbps_checker.sv =====
// Port-level checks on the serial output of the LED bar pattern shifter,
// attached to led_bar_pattern_shifter_core by the bind below.
module lbps_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_serial_bit,
   input logic rsp_latch_after
);

   // hold a stalled transaction unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_serial_bit)
                                  && $stable(rsp_latch_after))
      else $error("stalled rsp transaction changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // valid stays known once out of reset
   a_rsp_valid_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown(rsp_valid))
      else $error("rsp valid unknown");

endmodule

bind led_bar_pattern_shifter_core lbps_checker u_lbps_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_serial_bit  (rsp_if.serial_bit),
   .rsp_latch_after (rsp_if.latch_after)
);

// ===== tb/tb_led_bar_pattern_shifter_core.sv =====
// Self-checking testbench for led_bar_pattern_shifter_core: drives LED commands and
// full_scale writes, predicts each serial bit and compares it on the result channel.
// Depends on lbps_pkg, lbps_req_if, lbps_rsp_if and the core itself.
module tb_led_bar_pattern_shifter_core;
   import lbps_pkg::*;

   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int MAX_REPORTS   = 10;

   // LED index emitted in each serial slot, slot k in nibble k
   localparam logic [63:0] LED_ORDER = 64'hF89A_BCDE_7012_3456;

   localparam logic [FUNC_W-1:0] FUNC_RESERVED_A = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_RESERVED_B = 3'd7;
   localparam logic [MODE_W-1:0] DOT_RAW         = 3'd0;
   localparam logic [MODE_W-1:0] DOT_UNUSED      = 3'd7;
   localparam logic [MODE_W-1:0] BAR_UNUSED      = 3'd5;

   typedef struct packed {
      logic [FUNC_W-1:0]          func;
      logic [MODE_W-1:0]          mode;
      logic signed [AMOUNT_W-1:0] amount;
      logic [PATTERN_W-1:0]       new_pattern;
      logic [INDEX_W-1:0]         bit_index;
      logic                       bit_on;
   } led_cmd_type;

   typedef struct packed {
      logic serial_bit;
      logic latch_after;
   } serial_bit_type;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [FSCALE_W-1:0] csr_wr_data;

   lbps_req_if req_if();
   lbps_rsp_if rsp_if();

   led_bar_pattern_shifter_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predicted block state
   logic [PATTERN_W-1:0] led_state   = '0;
   logic                 led_dirty   = 1'b0;
   logic [FSCALE_W-1:0]  scale_value = FULL_SCALE_RESET;

   serial_bit_type expected_bits_q[$];
   int          mismatch_count = 0;
   int          burst_left     = 1;
   int          cycle_count    = 0;
   logic [15:0] stall_pat      = 16'hFFFF;
   int          stall_age      = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] mirror_byte(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = b[i];
      end
      return r;
   endfunction

   function automatic logic [PATTERN_W-1:0] low_ones(input longint n);
      return (n >= 16) ? 16'hFFFF : (16'hFFFF >> (16 - n));
   endfunction

   function automatic logic [PATTERN_W-1:0] level_bar(input logic [BAR_MODE_W-1:0] style,
                                                      input logic signed [AMOUNT_W-1:0] level);
      longint               fs;
      longint               lvl;
      longint               mag;
      longint               ratio;
      logic [PATTERN_W-1:0] mask;
      logic [7:0]           seg;
      logic [PATTERN_W-1:0] bar;
      fs  = (scale_value == '0) ? 1 : longint'(scale_value);
      lvl = longint'(level);
      mag = (lvl < 0) ? -lvl : lvl;
      if (style == BAR_PMBIT8 || style == BAR_PMLIN8) begin
         if (lvl >= fs) begin
            bar = PM_POS_FULL;
         end else if (lvl <= -fs) begin
            bar = PM_NEG_FULL;
         end else begin
            if (style == BAR_PMBIT8) begin
               ratio = mag * 255 / fs;
               seg   = ratio[7:0];
            end else begin
               mask = low_ones(mag * 8 / fs);
               seg  = mask[7:0];
            end
            bar = (lvl >= 0) ? {8'h00, mirror_byte(seg)} : {seg, 8'h00};
         end
      end else begin
         if (lvl <= 0) begin
            bar = '0;
         end else if (lvl > fs) begin
            bar = ALL_ON;
         end else if (style == BAR_PBIT16) begin
            ratio = mag * 65535 / fs;
            bar   = ratio[PATTERN_W-1:0];
         end else begin
            bar = low_ones(mag * 16 / fs);
         end
      end
      return bar;
   endfunction

   // update the predicted state and queue the serial bits a command causes
   function automatic void apply_led_command(input led_cmd_type c);
      logic [PATTERN_W-1:0] pos;
      logic [PATTERN_W-1:0] base;
      logic [PATTERN_W-1:0] next_pattern;
      logic [3:0]           led;
      int                   width;
      bit                   writes;
      serial_bit_type       sb;
      writes       = 1'b1;
      next_pattern = led_state;
      case (c.func)
         FUNC_LOAD: begin
            next_pattern = c.new_pattern;
         end
         FUNC_DOT: begin
            pos = c.amount[PATTERN_W-1:0];
            case (c.mode)
               DOT_W1: begin width = 1; base = 16'h0001; end
               DOT_W2: begin width = 2; base = 16'h0003; end
               DOT_W4: begin width = 4; base = 16'h000F; end
               DOT_W8: begin width = 8; base = 16'h00FF; end
               default: begin width = 0; base = '0; end
            endcase
            if (width == 0) begin
               next_pattern = pos;
            end else if (pos >= 16 / width) begin
               next_pattern = '0;
            end else begin
               next_pattern = base << (pos * width);
            end
         end
         FUNC_BAR: begin
            if (c.mode[2]) begin
               writes = 1'b0;
            end else begin
               next_pattern = level_bar(c.mode[BAR_MODE_W-1:0], c.amount);
            end
         end
         FUNC_SETBIT: begin
            if (c.bit_index >= 16) begin
               writes = 1'b0;
            end else begin
               next_pattern[c.bit_index[3:0]] = c.bit_on;
            end
         end
         FUNC_CLEAR: begin
            next_pattern = '0;
         end
         FUNC_REFRESH: begin
            writes = 1'b0;
            if (led_dirty) begin
               for (int k = 0; k < PATTERN_W; k++) begin
                  led            = LED_ORDER[4*k +: 4];
                  sb.serial_bit  = led_state[led];
                  sb.latch_after = (k == PATTERN_W - 1);
                  expected_bits_q.push_back(sb);
               end
               led_dirty = 1'b0;
            end
         end
         default: begin
            writes = 1'b0;
         end
      endcase
      if (writes) begin
         led_state = next_pattern;
         led_dirty = 1'b1;
      end
   endfunction

   function automatic led_cmd_type make_cmd(input logic [FUNC_W-1:0] func,
                                            input logic [MODE_W-1:0] mode,
                                            input logic signed [AMOUNT_W-1:0] amount,
                                            input logic [PATTERN_W-1:0] new_pattern,
                                            input logic [INDEX_W-1:0] bit_index,
                                            input logic bit_on);
      led_cmd_type c;
      c.func        = func;
      c.mode        = mode;
      c.amount      = amount;
      c.new_pattern = new_pattern;
      c.bit_index   = bit_index;
      c.bit_on      = bit_on;
      return c;
   endfunction

   // mostly levels around +/- full_scale, with the edges hit often
   function automatic logic signed [AMOUNT_W-1:0] pick_level();
      longint                     fs;
      longint                     v;
      logic signed [AMOUNT_W-1:0] raw;
      fs  = (scale_value == '0) ? 1 : longint'(scale_value);
      raw = AMOUNT_W'($urandom);
      case ($urandom_range(0, 11))
         0: v = fs;
         1: v = -fs;
         2: v = fs + 1;
         3: v = -fs - 1;
         4: v = fs - 1;
         5: v = 1 - fs;
         6: v = 0;
         7: v = longint'(raw);
         8: v = longint'($urandom_range(0, 600)) - 300;
         default: v = longint'($urandom_range(0, 2 * fs)) - fs;
      endcase
      if (v > 8388607) begin
         v = 8388607;
      end
      if (v < -8388608) begin
         v = -8388608;
      end
      return v[AMOUNT_W-1:0];
   endfunction

   function automatic led_cmd_type random_command();
      led_cmd_type c;
      int          pick;
      c.func        = FUNC_W'($urandom);
      c.mode        = MODE_W'($urandom);
      c.amount      = AMOUNT_W'($urandom);
      c.new_pattern = PATTERN_W'($urandom);
      c.bit_index   = INDEX_W'($urandom);
      c.bit_on      = 1'($urandom);
      pick          = $urandom_range(0, 99);
      if (pick < 12) begin
         c.func = FUNC_LOAD;
      end else if (pick < 30) begin
         c.func = FUNC_DOT;
         if ($urandom_range(0, 3) != 0) begin
            c.mode                  = MODE_W'($urandom_range(DOT_W1, DOT_W8));
            c.amount[PATTERN_W-1:0] = PATTERN_W'($urandom_range(0, 17));
         end
      end else if (pick < 55) begin
         c.func = FUNC_BAR;
         if ($urandom_range(0, 7) != 0) begin
            c.mode[2] = 1'b0;
         end
         c.amount = pick_level();
      end else if (pick < 68) begin
         c.func = FUNC_SETBIT;
         if ($urandom_range(0, 4) != 0) begin
            c.bit_index = INDEX_W'($urandom_range(0, 15));
         end
      end else if (pick < 73) begin
         c.func = FUNC_CLEAR;
      end else if (pick < 96) begin
         c.func = FUNC_REFRESH;
      end else begin
         c.func = $urandom_range(0, 1) ? FUNC_RESERVED_A : FUNC_RESERVED_B;
      end
      return c;
   endfunction

   // present one command, hold until accepted, then maybe idle between bursts
   task automatic send_cmd(input led_cmd_type c);
      req_if.valid       <= 1'b1;
      req_if.func        <= c.func;
      req_if.mode        <= c.mode;
      req_if.amount      <= c.amount;
      req_if.new_pattern <= c.new_pattern;
      req_if.bit_index   <= c.bit_index;
      req_if.bit_on      <= c.bit_on;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      apply_led_command(c);
      if (burst_left > 0) begin
         burst_left--;
      end
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
      end
   endtask

   // wait for every expected bit, then let queued non-output commands finish
   task automatic drain_pending();
      req_if.valid <= 1'b0;
      while (expected_bits_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_full_scale(input logic [FSCALE_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      scale_value = value;
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_random(input int count);
      repeat (count) send_cmd(random_command());
   endtask

   task automatic test_directed_cases();
      logic signed [AMOUNT_W-1:0] fs_level;
      fs_level = AMOUNT_W'(scale_value);
      send_cmd(make_cmd(FUNC_REFRESH, DOT_RAW, '0, 16'hFFFF, 8'd0, 1'b0));
      send_cmd(make_cmd(FUNC_LOAD, DOT_RAW, '0, 16'hA5C3, 8'd0, 1'b0));
      send_cmd(make_cmd(FUNC_REFRESH, DOT_RAW, '0, '0, 8'd0, 1'b0));
      send_cmd(make_cmd(FUNC_SETBIT, DOT_RAW, '0, '0, 8'd16, 1'b1));
      send_cmd(make_cmd(FUNC_SETBIT, DOT_RAW, '0, '0, 8'd255, 1'b1));
      send_cmd(make_cmd(FUNC_REFRESH, DOT_RAW, '0, '0, 8'd0, 1'b0));
      send_cmd(make_cmd(FUNC_SETBIT, DOT_RAW, '0, '0, 8'd0, 1'b0));
      send_cmd(make_cmd(FUNC_SETBIT, DOT_RAW, '0, '0, 8'd14, 1'b1));
      send_cmd(make_cmd(FUNC_REFRESH, DOT_RAW, '0, '0, 8'd0, 1'b0));
      send_cmd(make_cmd(FUNC_DOT, DOT_W8, 24'sd1, '0, 8'd0, 1'b0));
      send_cmd(make_cmd(FUNC_REFRESH, DOT_RAW, '0, '0, 8'd0, 1'b0));
      // dot lies wholly past bit 15: pattern goes dark but still dirty
      send_cmd(make_cmd(FUNC_DOT, DOT_W4, 24'sd4, '0, 8'd0, 1'b0));
      send_cmd(make_cmd(FUNC_REFRESH, DOT_RAW, '0, '0, 8'd0, 1'b0));
      send_cmd(make_cmd(FUNC_DOT, DOT_UNUSED, 24'sh80FFFF, 16'hFFFF, 8'd255, 1'b1));
      // meaningless bar style must leave the pattern alone
      send_cmd(make_cmd(FUNC_BAR, BAR_UNUSED, 24'sd100, '0, 8'd0, 1'b0));
      send_cmd(make_cmd(FUNC_REFRESH, DOT_RAW, '0, '0, 8'd0, 1'b0));
      send_cmd(make_cmd(FUNC_BAR, {1'b0, BAR_PMBIT8}, fs_level, '0, 8'd0, 1'b0));
      send_cmd(make_cmd(FUNC_REFRESH, DOT_RAW, '0, '0, 8'd0, 1'b0));
      send_cmd(make_cmd(FUNC_BAR, {1'b0, BAR_PMLIN8}, -fs_level, '0, 8'd0, 1'b0));
      send_cmd(make_cmd(FUNC_REFRESH, DOT_RAW, '0, '0, 8'd0, 1'b0));
      send_cmd(make_cmd(FUNC_BAR, {1'b0, BAR_PBIT16}, 24'sh7FFFFF, '0, 8'd0, 1'b0));
      send_cmd(make_cmd(FUNC_REFRESH, DOT_RAW, '0, '0, 8'd0, 1'b0));
      send_cmd(make_cmd(FUNC_BAR, {1'b0, BAR_PLIN16}, 24'sh800000, '0, 8'd0, 1'b0));
      send_cmd(make_cmd(FUNC_RESERVED_B, DOT_RAW, '0, 16'hFFFF, 8'd3, 1'b1));
      send_cmd(make_cmd(FUNC_CLEAR, DOT_RAW, '0, '0, 8'd0, 1'b0));
      send_cmd(make_cmd(FUNC_REFRESH, DOT_RAW, '0, '0, 8'd0, 1'b0));
   endtask

   task automatic test_random_traffic();
      run_random(100);
   endtask

   task automatic test_full_scale_sweep();
      drain_pending();
      write_full_scale(23'd1);
      run_random(40);
      drain_pending();
      write_full_scale(23'h7FFFFF);
      run_random(50);
      drain_pending();
      write_full_scale(FSCALE_W'($urandom_range(256, 4096)));
      run_random(40);
      drain_pending();
      write_full_scale(FSCALE_W'($urandom_range(1, 8388607)));
      run_random(50);
   endtask

   // a zero full_scale behaves as one
   task automatic test_zero_full_scale();
      drain_pending();
      write_full_scale('0);
      run_random(30);
   endtask

   // result channel: stall on a rotating pattern and check each transaction
   always @(posedge clock) begin : rsp_monitor
      serial_bit_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (expected_bits_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("unexpected serial bit: serial_bit=%b latch_after=%b",
                           rsp_if.serial_bit, rsp_if.latch_after);
               end
            end else begin
               want = expected_bits_q.pop_front();
               if (rsp_if.serial_bit !== want.serial_bit ||
                   rsp_if.latch_after !== want.latch_after) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("serial bit mismatch: expected %b/%b actual %b/%b",
                              want.serial_bit, want.latch_after,
                              rsp_if.serial_bit, rsp_if.latch_after);
                  end
               end
            end
         end
         stall_age++;
         if (stall_age >= 48) begin
            stall_age = 0;
            stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            if (stall_pat == '0) begin
               stall_pat = 16'h0001;
            end
         end else begin
            stall_pat = {stall_pat[0], stall_pat[15:1]};
         end
         rsp_if.ready <= stall_pat[0];
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("led_bar_pattern_shifter_core verification failed");
         $finish;
      end
   end

   initial begin
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= FULL_SCALE_RESET;
      req_if.valid       <= 1'b0;
      req_if.func        <= FUNC_LOAD;
      req_if.mode        <= DOT_RAW;
      req_if.amount      <= '0;
      req_if.new_pattern <= '0;
      req_if.bit_index   <= '0;
      req_if.bit_on      <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_traffic();
      test_full_scale_sweep();
      test_zero_full_scale();
      drain_pending();
      if (mismatch_count == 0 && expected_bits_q.size() == 0) begin
         $display("led_bar_pattern_shifter_core verification clean");
      end else begin
         $display("led_bar_pattern_shifter_core verification failed");
      end
      $finish;
   end

endmodule
